[hw/rtl/plc_pkg.sv]
`default_nettype none
package plc_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int WORD_W = 32;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_READ_AT     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_AT    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT_AT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE_AT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_APPEND      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REMOVE_LAST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ_LAST   = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    K_NONE,
    K_WRITE,
    K_INSERT,
    K_REMOVE,
    K_READ
  } plc_kind_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } plc_state_t;

endpackage
`default_nettype wire

[hw/rtl/plc_cell.sv]
`default_nettype none
module plc_cell
  import plc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire plc_kind_t         kind,
  input  wire logic [CW-1:0]     pos,
  input  wire logic [CW-1:0]     cnt,
  input  wire logic [WORD_W-1:0] value,
  input  wire logic [WORD_W-1:0] lo_word,
  input  wire logic [WORD_W-1:0] hi_word,
  input  wire logic [WORD_W-1:0] hi_pass,
  output logic      [WORD_W-1:0] word,
  output logic      [WORD_W-1:0] pass
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);
  localparam logic [CW-1:0] MY_P1  = CW'(IDX + 1);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] pass_r, pass_nxt;

  always_comb begin
    word_nxt = word_r;
    case (kind)
      K_WRITE: begin
        if (MY_IDX == pos) word_nxt = value;
      end
      K_INSERT: begin
        if (MY_IDX == pos) word_nxt = value;
        else if (MY_IDX > pos && MY_IDX <= cnt) word_nxt = lo_word;
      end
      K_REMOVE: begin
        if (MY_IDX >= pos && MY_P1 < cnt) word_nxt = hi_word;
      end
      default: word_nxt = word_r;
    endcase
    // read token moves one cell toward the head each cycle
    pass_nxt = (kind == K_READ && MY_IDX == pos) ? word_r : hi_pass;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pass_r <= pass_nxt;
  end

  assign word = word_r;
  assign pass = pass_r;

endmodule
`default_nettype wire

[hw/rtl/plc_chain.sv]
`default_nettype none
module plc_chain
  import plc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire plc_kind_t         kind,
  input  wire logic [CW-1:0]     pos,
  input  wire logic [CW-1:0]     cnt,
  input  wire logic [WORD_W-1:0] value,
  output logic      [WORD_W-1:0] head_pass
);

  logic [WORD_W-1:0] words  [DEPTH];
  logic [WORD_W-1:0] passes [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] lo_w, hi_w, hi_p;
    if (k == 0) begin : g_lo_end
      assign lo_w = '0;
    end else begin : g_lo
      assign lo_w = words[k-1];
    end
    if (k == DEPTH - 1) begin : g_hi_end
      assign hi_w = '0;
      assign hi_p = '0;
    end else begin : g_hi
      assign hi_w = words[k+1];
      assign hi_p = passes[k+1];
    end
    plc_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
      .clk    (clk),
      .kind   (kind),
      .pos    (pos),
      .cnt    (cnt),
      .value  (value),
      .lo_word(lo_w),
      .hi_word(hi_w),
      .hi_pass(hi_p),
      .word   (words[k]),
      .pass   (passes[k])
    );
  end

  assign head_pass = passes[0];

endmodule
`default_nettype wire

[hw/rtl/positional_list_engine_top.sv]
`default_nettype none
// positional list engine: ordered list of up to DEPTH signed 32-bit words
// input channel: in_valid/in_stall with in_action, in_position, in_value
// result channel: out_valid/out_stall with out_read_value, out_status,
//   out_count; exactly one result transfer per input transfer, in order
// write, insert, remove and append are broadcast to every cell in parallel
//   and remove_last only lowers the count; their result is registered at
//   the input transfer and offered on the next cycle, one item per cycle
//   while the output is not stalled; read_at position p and read_last
//   (p = count - 1) send the word down the cell chain one cell per cycle
//   toward the head, and the input is stalled until its result is registered
// a result that waits on out_stall sits in the output register; the next
//   item is taken as soon as the output register is free or being emptied
// reset empties the list (count zero); cell contents need no clearing
//   since no entry at or above the count is ever read
module positional_list_engine_top
  import plc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic        [ACT_W-1:0]  in_action,
  input  wire logic        [POS_W-1:0]  in_position,
  input  wire logic signed [WORD_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed      [WORD_W-1:0] out_read_value,
  output logic             [STAT_W-1:0] out_status,
  output logic             [CNT_W-1:0]  out_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  // wide enough to compare position against count without wrap
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

  plc_state_t state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [IW-1:0]     wait_r, wait_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_rd_r, out_rd_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic [CW-1:0]     out_cnt_r, out_cnt_nxt;

  // decode of the offered item against the current count
  plc_kind_t         dec_kind;
  logic [STAT_W-1:0] dec_status;
  logic [CW-1:0]     dec_pos;
  logic [CW-1:0]     dec_fill;
  logic [WW-1:0]     pos_w, cnt_w;

  logic              accept, out_free;
  plc_kind_t         cell_kind;
  logic [WORD_W-1:0] head_pass;

  assign pos_w = WW'(in_position);
  assign cnt_w = WW'(fill_r);

  always_comb begin
    dec_kind   = K_NONE;
    dec_status = ST_OK;
    dec_pos    = CW'(in_position);
    dec_fill   = fill_r;
    case (in_action)
      ACT_READ_AT, ACT_WRITE_AT, ACT_REMOVE_AT: begin
        if (fill_r == '0) dec_status = ST_EMPTY;
        else if (pos_w >= cnt_w) dec_status = ST_RANGE;
        else if (in_action == ACT_READ_AT) dec_kind = K_READ;
        else if (in_action == ACT_WRITE_AT) dec_kind = K_WRITE;
        else begin
          dec_kind = K_REMOVE;
          dec_fill = fill_r - 1'b1;
        end
      end
      ACT_INSERT_AT: begin
        if (pos_w > cnt_w) dec_status = ST_RANGE;
        else if (cnt_w >= DEPTH_W) dec_status = ST_FULL;
        else begin
          dec_kind = K_INSERT;
          dec_fill = fill_r + 1'b1;
        end
      end
      ACT_APPEND: begin
        dec_pos = fill_r;
        if (cnt_w >= DEPTH_W) dec_status = ST_FULL;
        else begin
          dec_kind = K_INSERT;
          dec_fill = fill_r + 1'b1;
        end
      end
      ACT_REMOVE_LAST: begin
        if (fill_r == '0) dec_status = ST_EMPTY;
        else dec_fill = fill_r - 1'b1;
      end
      ACT_READ_LAST: begin
        dec_pos = fill_r - 1'b1;
        if (fill_r == '0) dec_status = ST_EMPTY;
        else dec_kind = K_READ;
      end
      default: dec_kind = K_NONE;
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign cell_kind = accept ? dec_kind : K_NONE;

  plc_chain #(.DEPTH(DEPTH)) u_chain (
    .clk      (clk),
    .kind     (cell_kind),
    .pos      (dec_pos),
    .cnt      (fill_r),
    .value    (in_value),
    .head_pass(head_pass)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fill_nxt = dec_fill;
          if (dec_kind == K_READ) begin
            // token reaches the head when wait_r has counted down from dec_pos
            state_nxt = S_READ;
            wait_nxt  = IW'(dec_pos);
          end else begin
            out_valid_nxt = 1'b1;
            out_rd_nxt    = '0;
            out_st_nxt    = dec_status;
            out_cnt_nxt   = dec_fill;
          end
        end
      end
      S_READ: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_rd_nxt    = head_pass;
          out_st_nxt    = ST_OK;
          out_cnt_nxt   = fill_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wait_r    <= wait_nxt;
    out_rd_r  <= out_rd_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_st_r;
  assign out_count      = CNT_W'(out_cnt_r);

endmodule
`default_nettype wire

[test/tb.sv]
module tb;
  import plc_pkg::*;

  // list size under test and run control
  localparam int DEPTH        = DEPTH_DEF;
  localparam int RAND_PER_PH  = 667;   // random transfers per random phase
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;    // quiet cycles after the last result
  localparam int STALL_LIMIT  = 5000;  // cycles without any transfer

  // unused action code, the block treats it as no operation
  localparam logic [ACT_W-1:0] ACT_NOP = 3'd7;

  // one result transfer
  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic        [STAT_W-1:0] status;
    logic        [CNT_W-1:0]  count;
  } list_result_t;

  // one row of the directed script; fill means append until the list is full,
  // typed rows carry their own expected result
  typedef struct {
    logic        [ACT_W-1:0]  action;
    logic        [POS_W-1:0]  position;
    logic signed [WORD_W-1:0] value;
    bit                       fill;
    bit                       typed;
    list_result_t             res;
  } op_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic        [ACT_W-1:0]  in_action;
  logic        [POS_W-1:0]  in_position;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_read_value;
  logic        [STAT_W-1:0] out_status;
  logic        [CNT_W-1:0]  out_count;

  // predicted list contents and fill count
  logic signed [WORD_W-1:0] list_words [DEPTH];
  int                       list_len;

  // results still owed by the block, oldest first
  list_result_t pending_results [$];

  int err_count;
  int idle_cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;

  localparam int NROWS = 31;

  // directed script: empty-list errors, no-op, extreme words, first and last
  // forms of insert and remove, out-of-range positions, full list
  op_row_t script [NROWS] = '{
    '{ACT_READ_LAST,   5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{ACT_READ_AT,     5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{ACT_WRITE_AT,    5'd3,  32'h0000_0001, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{ACT_REMOVE_AT,   5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{ACT_REMOVE_LAST, 5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
    '{ACT_INSERT_AT,   5'd1,  32'h0000_0007, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd0}},
    '{ACT_NOP,         5'd31, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'sd0, ST_OK,    5'd0}},
    '{ACT_APPEND,      5'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, '{32'sd0, ST_OK,    5'd1}},
    '{ACT_INSERT_AT,   5'd0,  32'h8000_0000, 1'b0, 1'b1, '{32'sd0, ST_OK,    5'd2}},
    '{ACT_INSERT_AT,   5'd2,  32'hFFFF_FFFF, 1'b0, 1'b1, '{32'sd0, ST_OK,    5'd3}},
    '{ACT_INSERT_AT,   5'd1,  32'h5A5A_5A5A, 1'b0, 1'b1, '{32'sd0, ST_OK,    5'd4}},
    '{ACT_READ_AT,     5'd0,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_READ_AT,     5'd3,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_READ_LAST,   5'd0,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_READ_AT,     5'd4,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd4}},
    '{ACT_READ_AT,     5'd31, 32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd4}},
    '{ACT_WRITE_AT,    5'd2,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_WRITE_AT,    5'd4,  32'hA5A5_A5A5, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd4}},
    '{ACT_REMOVE_AT,   5'd0,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_REMOVE_AT,   5'd3,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd3}},
    '{ACT_INSERT_AT,   5'd4,  32'h0000_0000, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd3}},
    '{ACT_REMOVE_LAST, 5'd0,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_APPEND,      5'd0,  32'h0000_0000, 1'b1, 1'b0, '0},
    '{ACT_APPEND,      5'd0,  32'h0000_0001, 1'b0, 1'b1, '{32'sd0, ST_FULL,  5'd16}},
    '{ACT_INSERT_AT,   5'd0,  32'h0000_0001, 1'b0, 1'b1, '{32'sd0, ST_FULL,  5'd16}},
    '{ACT_INSERT_AT,   5'd16, 32'h0000_0001, 1'b0, 1'b1, '{32'sd0, ST_FULL,  5'd16}},
    '{ACT_INSERT_AT,   5'd17, 32'h0000_0001, 1'b0, 1'b1, '{32'sd0, ST_RANGE, 5'd16}},
    '{ACT_READ_AT,     5'd15, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_REMOVE_AT,   5'd15, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_INSERT_AT,   5'd15, 32'h1234_5678, 1'b0, 1'b0, '0},
    '{ACT_REMOVE_AT,   5'd0,  32'h0000_0000, 1'b0, 1'b0, '0}
  };

  positional_list_engine_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_count     (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one list operation to the predicted state and form its result
  function automatic void list_apply(input logic [ACT_W-1:0] act,
                                     input logic [POS_W-1:0] pos,
                                     input logic signed [WORD_W-1:0] val,
                                     output list_result_t res);
    int k;
    int at;
    res = '0;
    res.status = ST_OK;
    case (act)
      ACT_READ_AT, ACT_WRITE_AT, ACT_REMOVE_AT: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          res.status = ST_RANGE;
        end else if (act == ACT_READ_AT) begin
          res.read_value = list_words[pos];
        end else if (act == ACT_WRITE_AT) begin
          list_words[pos] = val;
        end else begin
          // close the gap toward the head
          for (k = int'(pos); k < list_len - 1; k++)
            list_words[k] = list_words[k + 1];
          list_len--;
        end
      end
      ACT_INSERT_AT, ACT_APPEND: begin
        at = (act == ACT_APPEND) ? list_len : int'(pos);
        // range is judged before fullness
        if (act == ACT_INSERT_AT && int'(pos) > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = list_len; k > at; k--)
            list_words[k] = list_words[k - 1];
          list_words[at] = val;
          list_len++;
        end
      end
      ACT_REMOVE_LAST: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      ACT_READ_LAST: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[list_len - 1];
      end
      default: begin
      end
    endcase
    res.count = list_len[CNT_W-1:0];
  endfunction

  // offer one item, called at a falling edge; returns at the falling edge
  // after its transfer, with the expected result queued
  task automatic offer_item(input logic [ACT_W-1:0] act,
                            input logic [POS_W-1:0] pos,
                            input logic signed [WORD_W-1:0] val,
                            input bit typed,
                            input list_result_t typed_res);
    list_result_t res;
    // sender idling between items
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    // hold the payload until the transfer
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    list_apply(act, pos, val, res);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // stimulus: reset, directed script, then three phases of random items
  initial begin
    int ph;
    int n;
    int r;
    bit grow;
    logic [ACT_W-1:0]         act;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = '0;
    in_position = '0;
    in_value    = '0;
    err_count   = 0;
    list_len    = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 38;
    rx_idle_pct = 83;

    // synchronous reset held, then released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (script[n]) begin
      if (script[n].fill) begin
        while (list_len < DEPTH)
          offer_item(ACT_APPEND, POS_W'($urandom_range(31)), $urandom, 1'b0, '0);
      end else begin
        offer_item(script[n].action, script[n].position, script[n].value,
                   script[n].typed, script[n].res);
      end
    end

    // random part: receiver slow, then sender slow, then no idling
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 38;
          rx_idle_pct = 83;
        end
        1: begin
          tx_idle_pct = 83;
          rx_idle_pct = 38;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // receiver stops for a long stretch while items keep coming
          hold_req = 1'b1;
        end
      endcase
      for (n = 0; n < RAND_PER_PH; n++) begin
        // alternate growing and shrinking so both full and empty are reached
        grow = ((n / 80) % 2) == 0;
        r = $urandom_range(99);
        if (r < 20) act = ACT_READ_AT;
        else if (r < 30) act = ACT_READ_LAST;
        else if (r < 40) act = ACT_WRITE_AT;
        else if (r < 45) act = ACT_NOP;
        else if ($urandom_range(99) < (grow ? 75 : 25))
          act = ($urandom_range(1) == 0) ? ACT_INSERT_AT : ACT_APPEND;
        else
          act = ($urandom_range(1) == 0) ? ACT_REMOVE_AT : ACT_REMOVE_LAST;

        // mostly legal positions, the rest anywhere in the field
        if ($urandom_range(99) < 20) pos = POS_W'($urandom_range(31));
        else if (act == ACT_INSERT_AT) pos = POS_W'($urandom_range(list_len));
        else if (list_len > 0) pos = POS_W'($urandom_range(list_len - 1));
        else pos = '0;

        // extreme words now and then
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'h0000_0000;
            default: val = 32'hFFFF_FFFF;
          endcase
        end else begin
          val = $urandom;
        end
        offer_item(act, pos, val, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    // drain the outstanding results, then a few quiet cycles
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side stall, with one long hold-off counted here
  initial begin
    int k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          err_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          err_count++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
hw/rtl/plc_pkg.sv
hw/rtl/plc_cell.sv
hw/rtl/plc_chain.sv
hw/rtl/positional_list_engine_top.sv
test/tb.sv
